// File: rtl/core/vmap_pkg.sv
// ----------------------------------------------------------------------------
// vmap_pkg
// Shared types and register addresses of the video memory access ports.
// ----------------------------------------------------------------------------
package vmap_pkg;

	localparam int VIDEO_DEPTH_DEF = 32768;
	localparam int PTR_W           = 15;
	localparam int TBL_WORDS       = 256;
	localparam int HIGH_ENTRIES    = 32;

	localparam logic [15:0] ADDR_OAM_RELOAD_LO = 16'h2102;
	localparam logic [15:0] ADDR_OAM_RELOAD_HI = 16'h2103;
	localparam logic [15:0] ADDR_OAM_DATA      = 16'h2104;
	localparam logic [15:0] ADDR_VRAM_MODE     = 16'h2115;
	localparam logic [15:0] ADDR_VRAM_PTR_LO   = 16'h2116;
	localparam logic [15:0] ADDR_VRAM_PTR_HI   = 16'h2117;
	localparam logic [15:0] ADDR_VRAM_DATA_LO  = 16'h2118;
	localparam logic [15:0] ADDR_VRAM_DATA_HI  = 16'h2119;
	localparam logic [15:0] ADDR_CGRAM_PTR     = 16'h2121;
	localparam logic [15:0] ADDR_CGRAM_DATA    = 16'h2122;
	localparam logic [15:0] ADDR_OAM_READ      = 16'h2138;
	localparam logic [15:0] ADDR_VRAM_READ_LO  = 16'h2139;
	localparam logic [15:0] ADDR_VRAM_READ_HI  = 16'h213A;
	localparam logic [15:0] ADDR_CGRAM_READ    = 16'h213B;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] reg_addr;
		logic [7:0]  write_data;
		logic        rendering;
	} vmap_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
	} vmap_rsp_t;

	typedef struct packed {
		logic [1:0]  we;
		logic [15:0] wdata;
	} vmap_wr_t;

endpackage

// File: rtl/core/vmap_ram.sv
// ----------------------------------------------------------------------------
// vmap_ram
// Word memory with byte-lane write enables and registered read data.
// ----------------------------------------------------------------------------
module vmap_ram
	import vmap_pkg::*;
#(
	parameter int DEPTH = TBL_WORDS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  vmap_wr_t      wr,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we[0]) begin
			mem[waddr][7:0] <= wr.wdata[7:0];
		end
		if (wr.we[1]) begin
			mem[waddr][15:8] <= wr.wdata[15:8];
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/vmap_vidx.sv
// ----------------------------------------------------------------------------
// vmap_vidx
// Video word index: field rotation and reciprocal multiply in one stage,
// remainder correction after it.
// ----------------------------------------------------------------------------
module vmap_vidx
	import vmap_pkg::*;
#(
	parameter int VIDEO_DEPTH = VIDEO_DEPTH_DEF,
	parameter int AW          = $clog2(VIDEO_DEPTH)
) (
	input  logic             clk,
	input  logic [PTR_W-1:0] ptr,
	input  logic [1:0]       rot,
	output logic [AW-1:0]    index
);

	localparam int     SHIFT = 30;
	localparam longint RECIP = (64'd1 << SHIFT) / VIDEO_DEPTH;
	localparam int     RW    = $clog2(RECIP + 1);
	localparam int     PW    = PTR_W + RW;
	localparam int     QW    = $clog2(32768 / VIDEO_DEPTH + 1);

	logic [PTR_W-1:0] a_rot;
	logic [PW-1:0]    prod;
	logic [PTR_W-1:0] a_s1;
	logic [QW-1:0]    q_s1;
	logic [15:0]      rem;
	logic [15:0]      rem_fix;

	always_comb begin
		a_rot = ptr;
		unique case (rot)
			2'd1:    a_rot[7:0] = {ptr[4:0], ptr[7:5]};
			2'd2:    a_rot[8:0] = {ptr[5:0], ptr[8:6]};
			2'd3:    a_rot[9:0] = {ptr[6:0], ptr[9:7]};
			default: a_rot = ptr;
		endcase
		prod = PW'(a_rot) * PW'(RECIP);
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_rot;
		q_s1 <= prod[SHIFT +: QW];
	end

	always_comb begin
		rem     = 16'(a_s1) - 16'(32'(q_s1) * VIDEO_DEPTH);
		rem_fix = (32'(rem) >= VIDEO_DEPTH) ? 16'(32'(rem) - VIDEO_DEPTH) : rem;
		index   = rem_fix[AW-1:0];
	end

endmodule

// File: rtl/core/video_memory_access_ports.sv
// ----------------------------------------------------------------------------
// video_memory_access_ports
// Byte-wide register ports into video RAM, sprite attribute and palette memory.
// ----------------------------------------------------------------------------
// From acceptance to a registered response, a transaction proceeds thus:
// the cycle of acceptance computes the rotated video pointer and its reciprocal
// multiply, the next reduces it modulo VIDEO_DEPTH and reads all three
// memories, the last modifies state, writes the memories back and loads the
// response register. A new transaction is accepted once the response has been
// taken. After reset a clearing pass writes zero to every memory word, and
// no transaction is accepted until that pass is done.
module video_memory_access_ports
	import vmap_pkg::*;
#(
	parameter int VIDEO_DEPTH = VIDEO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  vmap_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output vmap_rsp_t rsp
);

	localparam int AW = $clog2(VIDEO_DEPTH);
	localparam int TW = $clog2(TBL_WORDS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_MOD   = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    clr_q;
	vmap_req_t        txn_q;
	logic [AW-1:0]    vidx_q;
	logic [9:0]       sp_q;
	logic [7:0]       rl_q;
	logic [7:0]       rh_q;
	logic [7:0]       sl_q;
	logic [7:0]       sh_q [HIGH_ENTRIES];
	logic [PTR_W-1:0] vp_q;
	logic [7:0]       vm_q;
	logic [7:0]       pf_lo_q;
	logic [7:0]       pf_hi_q;
	logic [8:0]       pp_q;
	logic [7:0]       pl_q;
	logic             rsp_valid_q;
	vmap_rsp_t        rsp_q;

	logic             acc;
	logic [PTR_W-1:0] ptr_eff;
	logic [AW-1:0]    vidx;
	logic [PTR_W-1:0] vp_step;
	logic             busy;
	logic [7:0]       wd;
	vmap_wr_t         vr_wr;
	vmap_wr_t         sr_wr;
	vmap_wr_t         pr_wr;
	logic [AW-1:0]    vr_waddr;
	logic [TW-1:0]    sr_waddr;
	logic [TW-1:0]    pr_waddr;
	logic [15:0]      vr_rdata;
	logic [15:0]      sr_rdata;
	logic [15:0]      pr_rdata;
	vmap_rsp_t        rsp_next;

	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign busy      = txn_q.rendering;
	assign wd        = txn_q.write_data;

	always_comb begin
		ptr_eff = vp_q;
		if (req.op == OP_WRITE && req.reg_addr == ADDR_VRAM_PTR_LO) begin
			ptr_eff = {vp_q[14:8], req.write_data};
		end else if (req.op == OP_WRITE && req.reg_addr == ADDR_VRAM_PTR_HI) begin
			ptr_eff = {req.write_data[6:0], vp_q[7:0]};
		end
	end

	vmap_vidx #(
		.VIDEO_DEPTH(VIDEO_DEPTH),
		.AW         (AW)
	) u_vidx (
		.clk  (clk),
		.ptr  (ptr_eff),
		.rot  (vm_q[3:2]),
		.index(vidx)
	);

	always_comb begin
		unique case (vm_q[1:0])
			2'd0:    vp_step = PTR_W'(vp_q + PTR_W'(1));
			2'd1:    vp_step = PTR_W'(vp_q + PTR_W'(32));
			default: vp_step = PTR_W'(vp_q + PTR_W'(128));
		endcase
	end

	// memory write requests
	always_comb begin
		vr_wr    = '{we: 2'b00, wdata: {wd, wd}};
		sr_wr    = '{we: 2'b00, wdata: {wd, sl_q}};
		pr_wr    = '{we: 2'b00, wdata: {wd, pl_q}};
		vr_waddr = vidx_q;
		sr_waddr = sp_q[8:1];
		pr_waddr = pp_q[8:1];
		if (state_q == ST_CLEAR) begin
			vr_wr    = '{we: 2'b11, wdata: 16'h0000};
			sr_wr    = '{we: 2'b11, wdata: 16'h0000};
			pr_wr    = '{we: 2'b11, wdata: 16'h0000};
			vr_waddr = clr_q;
			sr_waddr = clr_q[TW-1:0];
			pr_waddr = clr_q[TW-1:0];
		end else if (state_q == ST_EXEC && txn_q.op == OP_WRITE && !busy) begin
			if (txn_q.reg_addr == ADDR_VRAM_DATA_LO) begin
				vr_wr.we = 2'b01;
			end
			if (txn_q.reg_addr == ADDR_VRAM_DATA_HI) begin
				vr_wr.we = 2'b10;
			end
			if (txn_q.reg_addr == ADDR_OAM_DATA && sp_q[0] && !sp_q[9]) begin
				sr_wr.we = 2'b11;
			end
			if (txn_q.reg_addr == ADDR_CGRAM_DATA && pp_q[0]) begin
				pr_wr.we = 2'b11;
			end
		end
	end

	vmap_ram #(.DEPTH(VIDEO_DEPTH), .AW(AW)) u_vram (
		.clk  (clk),
		.wr   (vr_wr),
		.waddr(vr_waddr),
		.raddr(vidx),
		.rdata(vr_rdata)
	);

	vmap_ram #(.DEPTH(TBL_WORDS), .AW(TW)) u_oam (
		.clk  (clk),
		.wr   (sr_wr),
		.waddr(sr_waddr),
		.raddr(sp_q[8:1]),
		.rdata(sr_rdata)
	);

	vmap_ram #(.DEPTH(TBL_WORDS), .AW(TW)) u_cgram (
		.clk  (clk),
		.wr   (pr_wr),
		.waddr(pr_waddr),
		.raddr(pp_q[8:1]),
		.rdata(pr_rdata)
	);

	always_comb begin
		rsp_next = '{read_data: 8'h00, read_valid: 1'b0};
		if (txn_q.op == OP_READ && !busy) begin
			unique case (txn_q.reg_addr)
				ADDR_OAM_READ: begin
					rsp_next.read_valid = 1'b1;
					if (sp_q[9]) begin
						rsp_next.read_data = sh_q[sp_q[4:0]];
					end else begin
						rsp_next.read_data = sp_q[0] ? sr_rdata[15:8] : sr_rdata[7:0];
					end
				end
				ADDR_VRAM_READ_LO: begin
					rsp_next = '{read_data: pf_lo_q, read_valid: 1'b1};
				end
				ADDR_VRAM_READ_HI: begin
					rsp_next = '{read_data: pf_hi_q, read_valid: 1'b1};
				end
				ADDR_CGRAM_READ: begin
					rsp_next.read_valid = 1'b1;
					rsp_next.read_data  = pp_q[0] ? pr_rdata[15:8] : pr_rdata[7:0];
				end
				default: begin
					rsp_next = '{read_data: 8'h00, read_valid: 1'b0};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			rl_q        <= '0;
			rh_q        <= '0;
			sl_q        <= '0;
			vp_q        <= '0;
			vm_q        <= '0;
			pf_lo_q     <= '0;
			pf_hi_q     <= '0;
			pp_q        <= '0;
			pl_q        <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < HIGH_ENTRIES; i++) begin
				sh_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + AW'(1));
					if (clr_q == AW'(VIDEO_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
					if (txn_q.op == OP_READ) begin
						if (!busy) begin
							unique case (txn_q.reg_addr)
								ADDR_OAM_READ: sp_q <= 10'(sp_q + 10'd1);
								ADDR_VRAM_READ_LO: begin
									pf_lo_q <= vr_rdata[7:0];
									if (!vm_q[7]) vp_q <= vp_step;
								end
								ADDR_VRAM_READ_HI: begin
									pf_hi_q <= vr_rdata[15:8];
									if (vm_q[7]) vp_q <= vp_step;
								end
								ADDR_CGRAM_READ: pp_q <= 9'(pp_q + 9'd1);
								default: ;
							endcase
						end
					end else begin
						unique case (txn_q.reg_addr)
							ADDR_OAM_RELOAD_LO: begin
								rl_q <= wd;
								sp_q <= {rh_q[0], wd, 1'b0};
							end
							ADDR_OAM_RELOAD_HI: begin
								rh_q <= wd;
								sp_q <= {wd[0], rl_q, 1'b0};
							end
							ADDR_VRAM_MODE: vm_q <= wd;
							ADDR_VRAM_PTR_LO: begin
								vp_q    <= {vp_q[14:8], wd};
								pf_lo_q <= vr_rdata[7:0];
								pf_hi_q <= vr_rdata[15:8];
							end
							ADDR_VRAM_PTR_HI: begin
								vp_q    <= {wd[6:0], vp_q[7:0]};
								pf_lo_q <= vr_rdata[7:0];
								pf_hi_q <= vr_rdata[15:8];
							end
							ADDR_CGRAM_PTR: pp_q <= {wd, 1'b0};
							ADDR_OAM_DATA: begin
								if (!busy) begin
									if (!sp_q[0]) sl_q <= wd;
									if (sp_q[9]) sh_q[sp_q[4:0]] <= wd;
									sp_q <= 10'(sp_q + 10'd1);
								end
							end
							ADDR_VRAM_DATA_LO: begin
								if (!busy && !vm_q[7]) vp_q <= vp_step;
							end
							ADDR_VRAM_DATA_HI: begin
								if (!busy && vm_q[7]) vp_q <= vp_step;
							end
							ADDR_CGRAM_DATA: begin
								if (!busy) begin
									if (!pp_q[0]) pl_q <= wd;
									pp_q <= 9'(pp_q + 9'd1);
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			txn_q <= req;
		end
		if (state_q == ST_MOD) begin
			vidx_q <= vidx;
		end
		if (state_q == ST_EXEC) begin
			rsp_q <= rsp_next;
		end
	end

	a_acc_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##3 rsp_valid_q)
		else $error("response not loaded three cycles after acceptance");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (vr_wr.we == 2'b00 && sr_wr.we == 2'b00 &&
			pr_wr.we == 2'b00))
		else $error("memory written while idle");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.read_valid) |-> (rsp_q.read_data == 8'h00))
		else $error("nonzero data on an unserved read");

endmodule

// File: tb/video_memory_access_ports_test.sv
// ----------------------------------------------------------------------------
// video_memory_access_ports_test
// Drives register reads and writes into the video memory access ports and
// checks every response against a behavioral model of the three memories,
// with random idle cycles on both the request and the response side.
// ----------------------------------------------------------------------------
module video_memory_access_ports_test;
	import vmap_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = VIDEO_DEPTH_DEF;
	localparam int STALL_LIMIT = 4 * DEPTH + 2000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	vmap_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	vmap_rsp_t rsp;

	logic [15:0] mdl_vram [DEPTH];
	logic [7:0]  mdl_oam_lo [512];
	logic [7:0]  mdl_oam_hi [32];
	logic [7:0]  mdl_cgram [512];
	logic [9:0]  mdl_oam_ptr;
	logic [7:0]  mdl_reload_lo;
	logic [7:0]  mdl_reload_hi;
	logic [7:0]  mdl_oam_latch;
	logic [14:0] mdl_vram_ptr;
	logic [7:0]  mdl_vram_mode;
	logic [7:0]  mdl_pre_lo;
	logic [7:0]  mdl_pre_hi;
	logic [8:0]  mdl_cgram_ptr;
	logic [7:0]  mdl_cgram_latch;

	vmap_rsp_t pending_rsp [$];
	int        fail_count;
	int        idle_cycles;

	video_memory_access_ports #(
		.VIDEO_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int vram_index();
		logic [14:0] a;
		logic [9:0]  f;
		int          sel;
		int          bits;
		a = mdl_vram_ptr;
		sel = int'(mdl_vram_mode[3:2]);
		if (sel != 0) begin
			bits = 7 + sel;
			f = 10'(a & ((1 << bits) - 1));
			f = 10'(((f << 3) | (f >> (bits - 3))) & ((1 << bits) - 1));
			a = 15'((a & ~((1 << bits) - 1)) | f);
		end
		return int'(a) % DEPTH;
	endfunction

	function automatic void vram_advance(bit after_high);
		int stride;
		stride = (mdl_vram_mode[1:0] == 0) ? 1 : (mdl_vram_mode[1:0] == 1) ? 32 : 128;
		if (after_high == mdl_vram_mode[7])
			mdl_vram_ptr = 15'(mdl_vram_ptr + 15'(stride));
	endfunction

	function automatic void vram_prefetch();
		logic [15:0] w;
		w = mdl_vram[vram_index()];
		mdl_pre_lo = w[7:0];
		mdl_pre_hi = w[15:8];
	endfunction

	function automatic vmap_rsp_t port_access(vmap_req_t t);
		vmap_rsp_t r;
		int        i;
		r = '0;
		if (t.op == OP_READ) begin
			if (!t.rendering && t.reg_addr >= ADDR_OAM_READ && t.reg_addr <= ADDR_CGRAM_READ) begin
				r.read_valid = 1'b1;
				if (t.reg_addr == ADDR_OAM_READ) begin
					r.read_data = mdl_oam_ptr[9] ? mdl_oam_hi[mdl_oam_ptr[4:0]]
						: mdl_oam_lo[mdl_oam_ptr[8:0]];
					mdl_oam_ptr = 10'(mdl_oam_ptr + 10'd1);
				end else if (t.reg_addr == ADDR_VRAM_READ_LO) begin
					r.read_data = mdl_pre_lo;
					mdl_pre_lo = mdl_vram[vram_index()][7:0];
					vram_advance(1'b0);
				end else if (t.reg_addr == ADDR_VRAM_READ_HI) begin
					r.read_data = mdl_pre_hi;
					mdl_pre_hi = mdl_vram[vram_index()][15:8];
					vram_advance(1'b1);
				end else begin
					r.read_data = mdl_cgram[mdl_cgram_ptr];
					mdl_cgram_ptr = 9'(mdl_cgram_ptr + 9'd1);
				end
			end
		end else if (t.reg_addr == ADDR_OAM_RELOAD_LO || t.reg_addr == ADDR_OAM_RELOAD_HI) begin
			if (t.reg_addr == ADDR_OAM_RELOAD_LO)
				mdl_reload_lo = t.write_data;
			else
				mdl_reload_hi = t.write_data;
			mdl_oam_ptr = {mdl_reload_hi[0], mdl_reload_lo, 1'b0};
		end else if (t.reg_addr == ADDR_VRAM_MODE) begin
			mdl_vram_mode = t.write_data;
		end else if (t.reg_addr == ADDR_VRAM_PTR_LO) begin
			mdl_vram_ptr[7:0] = t.write_data;
			vram_prefetch();
		end else if (t.reg_addr == ADDR_VRAM_PTR_HI) begin
			mdl_vram_ptr[14:8] = t.write_data[6:0];
			vram_prefetch();
		end else if (t.reg_addr == ADDR_CGRAM_PTR) begin
			mdl_cgram_ptr = {t.write_data, 1'b0};
		end else if (!t.rendering) begin
			if (t.reg_addr == ADDR_OAM_DATA) begin
				if (!mdl_oam_ptr[0])
					mdl_oam_latch = t.write_data;
				else if (!mdl_oam_ptr[9]) begin
					mdl_oam_lo[mdl_oam_ptr[8:0] - 1] = mdl_oam_latch;
					mdl_oam_lo[mdl_oam_ptr[8:0]] = t.write_data;
				end
				if (mdl_oam_ptr[9])
					mdl_oam_hi[mdl_oam_ptr[4:0]] = t.write_data;
				mdl_oam_ptr = 10'(mdl_oam_ptr + 10'd1);
			end else if (t.reg_addr == ADDR_VRAM_DATA_LO) begin
				i = vram_index();
				mdl_vram[i][7:0] = t.write_data;
				vram_advance(1'b0);
			end else if (t.reg_addr == ADDR_VRAM_DATA_HI) begin
				i = vram_index();
				mdl_vram[i][15:8] = t.write_data;
				vram_advance(1'b1);
			end else if (t.reg_addr == ADDR_CGRAM_DATA) begin
				if (!mdl_cgram_ptr[0])
					mdl_cgram_latch = t.write_data;
				else begin
					mdl_cgram[mdl_cgram_ptr - 1] = mdl_cgram_latch;
					mdl_cgram[mdl_cgram_ptr] = t.write_data;
				end
				mdl_cgram_ptr = 9'(mdl_cgram_ptr + 9'd1);
			end
		end
		return r;
	endfunction

	task automatic send(logic op, logic [15:0] addr, logic [7:0] data, logic busy = 1'b0);
		vmap_req_t t;
		int        gap;
		t.op = op;
		t.reg_addr = addr;
		t.write_data = data;
		t.rendering = busy;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= t;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(port_access(t));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response with nothing expected");
				fail_count++;
			end else begin
				if (rsp.read_data !== pending_rsp[0].read_data) begin
					$error("read_data expected %0h actual %0h", pending_rsp[0].read_data,
						rsp.read_data);
					fail_count++;
				end
				if (rsp.read_valid !== pending_rsp[0].read_valid) begin
					$error("read_valid expected %0h actual %0h", pending_rsp[0].read_valid,
						rsp.read_valid);
					fail_count++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (rsp_valid && !rsp_stall) begin
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			rsp_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_vram_directed();
		send(OP_WRITE, ADDR_VRAM_MODE, 8'h80);
		send(OP_WRITE, ADDR_VRAM_PTR_LO, 8'hFF);
		send(OP_WRITE, ADDR_VRAM_PTR_HI, 8'hFF);
		send(OP_WRITE, ADDR_VRAM_DATA_LO, 8'hA5);
		send(OP_WRITE, ADDR_VRAM_DATA_HI, 8'h5A);
		send(OP_WRITE, ADDR_VRAM_PTR_HI, 8'h7F);
		send(OP_READ, ADDR_VRAM_READ_LO, 8'h00);
		send(OP_READ, ADDR_VRAM_READ_HI, 8'h00);
		send(OP_WRITE, ADDR_VRAM_MODE, 8'h0F);
		send(OP_WRITE, ADDR_VRAM_DATA_LO, 8'h00);
		send(OP_WRITE, ADDR_VRAM_DATA_LO, 8'h11, 1'b1);
		send(OP_READ, ADDR_VRAM_READ_LO, 8'h00, 1'b1);
	endtask

	task automatic test_oam_cgram_directed();
		send(OP_WRITE, ADDR_OAM_RELOAD_HI, 8'hFF);
		send(OP_WRITE, ADDR_OAM_RELOAD_LO, 8'hFF);
		send(OP_WRITE, ADDR_OAM_DATA, 8'h12);
		send(OP_WRITE, ADDR_OAM_DATA, 8'h34);
		send(OP_WRITE, ADDR_OAM_RELOAD_HI, 8'h00);
		send(OP_READ, ADDR_OAM_READ, 8'h00);
		send(OP_WRITE, ADDR_CGRAM_PTR, 8'hFF);
		send(OP_WRITE, ADDR_CGRAM_DATA, 8'hFF);
		send(OP_WRITE, ADDR_CGRAM_DATA, 8'hEE);
		send(OP_READ, ADDR_CGRAM_READ, 8'h00);
		send(OP_READ, 16'hFFFF, 8'h00);
		send(OP_WRITE, 16'h0000, 8'hFF);
	endtask

	function automatic logic [15:0] pick_addr();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 16'($urandom);
		else if (k < 6)
			return ADDR_OAM_READ + 16'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: return ADDR_OAM_RELOAD_LO;
			1: return ADDR_OAM_RELOAD_HI;
			2: return ADDR_OAM_DATA;
			3: return ADDR_VRAM_MODE;
			4: return ADDR_VRAM_PTR_LO;
			5: return ADDR_VRAM_PTR_HI;
			6: return ADDR_VRAM_DATA_LO;
			7: return ADDR_VRAM_DATA_HI;
			8: return ADDR_CGRAM_PTR;
			default: return ADDR_CGRAM_DATA;
		endcase
	endfunction

	task automatic test_random(int count);
		logic [15:0] a;
		logic [7:0]  d;
		for (int n = 0; n < count; n++) begin
			a = pick_addr();
			d = 8'($urandom);
			if (a == ADDR_VRAM_PTR_HI && $urandom_range(0, 1))
				d = d & 8'h01;
			send(logic'($urandom_range(0, 1)), a, d, logic'($urandom_range(0, 9) == 0));
			if (n == count / 2)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		fail_count = 0;
		idle_cycles = 0;
		foreach (mdl_vram[i]) mdl_vram[i] = '0;
		foreach (mdl_oam_lo[i]) mdl_oam_lo[i] = '0;
		foreach (mdl_oam_hi[i]) mdl_oam_hi[i] = '0;
		foreach (mdl_cgram[i]) mdl_cgram[i] = '0;
		mdl_oam_ptr = '0;
		mdl_reload_lo = '0;
		mdl_reload_hi = '0;
		mdl_oam_latch = '0;
		mdl_vram_ptr = '0;
		mdl_vram_mode = '0;
		mdl_pre_lo = '0;
		mdl_pre_hi = '0;
		mdl_cgram_ptr = '0;
		mdl_cgram_latch = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_vram_directed();
		test_oam_cgram_directed();
		test_random(1530);
		wait_drained();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
